// ===== design/assert_macros.svh =====
// Assertion helpers shared by the RTL modules.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every sampled edge.
`define TCW_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define TCW_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tcw_pkg.sv =====
`default_nettype none

package tcw_pkg;

    // Screen geometry
    localparam int COLUMNS  = 80;
    localparam int ROWS     = 25;
    localparam int TAB_STEP = 4;
    localparam int CELLS    = ROWS * COLUMNS;

    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CHAR_W = 8;
    localparam int CELL_W = 2 * CHAR_W;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

    // Attribute reset and blank cell after reset
    localparam logic [CHAR_W-1:0] RESET_COLOR = 8'h30;
    localparam logic [CELL_W-1:0] RESET_BLANK = {RESET_COLOR, CH_SPACE};

    // Item function codes
    localparam logic FUNC_PUT  = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ADDR,
        S_ACCESS,
        S_SCROLL,
        S_DONE
    } tcw_state_t;

    // Controller to datapath
    typedef struct packed {
        logic clear_step;
        logic load_in;
        logic calc_addr;
        logic access;
        logic scroll_step;
        logic load_out;
    } tcw_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_last;
        logic scroll_need;
        logic scroll_last;
        logic out_free;
    } tcw_sts_t;

endpackage

`default_nettype wire

// ===== design/tcw_ctrl.sv =====
`default_nettype none

`include "assert_macros.svh"

module tcw_ctrl
    import tcw_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire tcw_sts_t sts,
    output tcw_cmd_t      cmd
);

    tcw_state_t state_reg;
    tcw_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_ADDR;
                end
            end
            S_ADDR:
            begin
                cmd.calc_addr = 1'b1;
                state_next    = S_ACCESS;
            end
            S_ACCESS:
            begin
                cmd.access = 1'b1;
                state_next = sts.scroll_need ? S_SCROLL : S_DONE;
            end
            S_SCROLL:
            begin
                cmd.scroll_step = 1'b1;
                if (sts.scroll_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Checks
    `TCW_ASSERT_NEXT(a_scroll_follows, (state_reg == S_ACCESS) && sts.scroll_need, state_reg == S_SCROLL, "scroll not started after overflow")
    `TCW_ASSERT_IMPL(a_load_out_free, cmd.load_out, sts.out_free, "result loaded over a waiting beat")
    `TCW_ASSERT_NEXT(a_idle_after_load, cmd.load_out, in_ready, "not ready after result load")

endmodule

`default_nettype wire

// ===== design/tcw_datapath.sv =====
`default_nettype none

`include "assert_macros.svh"

module tcw_datapath
    import tcw_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire tcw_cmd_t          cmd,
    output tcw_sts_t               sts,
    input  wire logic              cfg_wr_en,
    input  wire logic [CHAR_W-1:0] cfg_wr_data,
    input  wire logic              func,
    input  wire logic [CHAR_W-1:0] char_code,
    input  wire logic [ROW_W-1:0]  read_row,
    input  wire logic [COL_W-1:0]  read_col,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [CELL_W-1:0]      cell_value,
    output logic [ROW_W-1:0]       cursor_row_out,
    output logic [COL_W-1:0]       cursor_col_out,
    output logic                   scrolled
);

    localparam logic [ADDR_W-1:0] COLUMNS_A = ADDR_W'(COLUMNS);

    // Control state
    logic [CHAR_W-1:0] text_color_reg;
    logic [ROW_W-1:0]  cursor_row_reg;
    logic [COL_W-1:0]  cursor_col_reg;
    logic [ROW_W-1:0]  top_reg;        // physical row holding screen row 0
    logic [ADDR_W-1:0] addr_reg;
    logic [COL_W-1:0]  cnt_reg;
    logic              out_valid_reg;

    // Latched item
    logic              func_reg;
    logic [CHAR_W-1:0] char_reg;
    logic [ROW_W-1:0]  rrow_reg;
    logic [COL_W-1:0]  rcol_reg;
    logic              in_range_reg;
    logic              scrolled_reg;

    // Result register
    logic [CELL_W-1:0] cell_out_reg;
    logic [ROW_W-1:0]  row_out_reg;
    logic [COL_W-1:0]  col_out_reg;
    logic              scrolled_out_reg;

    // Cell store
    logic [CELL_W-1:0] mem [CELLS];
    logic [CELL_W-1:0] rd_q_reg;

    logic              is_nl;
    logic              is_tab;
    logic              is_bs;
    logic [COL_W-1:0]  wcol;
    logic [ROW_W-1:0]  row_sel;
    logic [COL_W-1:0]  col_sel;
    logic [ROW_W:0]    phys_sum;
    logic [ROW_W-1:0]  phys_row;
    logic [ADDR_W-1:0] addr_calc;
    logic              in_range;
    logic [COL_W:0]    col_adv;
    logic [ROW_W:0]    row_adv;
    logic [COL_W-1:0]  col_next;
    logic [ROW_W-1:0]  row_next;
    logic              scroll_need;
    logic              mem_we;
    logic [CELL_W-1:0] mem_wdata;

    // Character decode
    assign is_nl  = (char_reg == CH_NEWLINE);
    assign is_tab = (char_reg == CH_TAB);
    assign is_bs  = (char_reg == CH_BACKSPACE);

    // Backspace column saturates at zero
    assign wcol = (is_bs && (cursor_col_reg != '0)) ? cursor_col_reg - COL_W'(1)
                                                    : cursor_col_reg;

    // Screen row/col to store address through the scroll offset
    always_comb
    begin
        row_sel  = (func_reg == FUNC_READ) ? rrow_reg : cursor_row_reg;
        col_sel  = (func_reg == FUNC_READ) ? rcol_reg : wcol;
        phys_sum = {1'b0, row_sel} + {1'b0, top_reg};
        if (phys_sum >= (ROW_W+1)'(ROWS))
        begin
            phys_sum = phys_sum - (ROW_W+1)'(ROWS);
        end
        phys_row  = phys_sum[ROW_W-1:0];
        addr_calc = ADDR_W'(phys_row) * COLUMNS_A + ADDR_W'(col_sel);
        in_range  = (func_reg == FUNC_PUT) ||
                    ((32'(rrow_reg) < ROWS) && (32'(rcol_reg) < COLUMNS));
    end

    // Cursor advance for a put
    always_comb
    begin
        row_adv = {1'b0, cursor_row_reg};
        priority if (is_nl)
        begin
            col_adv = '0;
            row_adv = row_adv + (ROW_W+1)'(1);
        end
        else if (is_tab)
        begin
            col_adv = {1'b0, cursor_col_reg} + (COL_W+1)'(TAB_STEP);
        end
        else if (is_bs)
        begin
            col_adv = {1'b0, wcol};
        end
        else
        begin
            col_adv = {1'b0, cursor_col_reg} + (COL_W+1)'(1);
        end
        if (32'(col_adv) >= COLUMNS)
        begin
            col_adv = '0;
            row_adv = row_adv + (ROW_W+1)'(1);
        end
        scroll_need = (func_reg == FUNC_PUT) && (32'(row_adv) >= ROWS);
        col_next    = col_adv[COL_W-1:0];
        row_next    = scroll_need ? ROW_W'(ROWS - 1) : row_adv[ROW_W-1:0];
    end

    // Store write port
    always_comb
    begin
        mem_we    = cmd.clear_step || cmd.scroll_step ||
                    (cmd.access && (func_reg == FUNC_PUT) && !is_nl);
        mem_wdata = {text_color_reg, (is_tab || is_bs) ? CH_SPACE : char_reg};
        if (cmd.clear_step)
        begin
            mem_wdata = RESET_BLANK;
        end
        else if (cmd.scroll_step)
        begin
            mem_wdata = {text_color_reg, CH_SPACE};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[addr_reg] <= mem_wdata;
        end
        rd_q_reg <= mem[addr_reg];
    end

    // Attribute register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_color_reg <= RESET_COLOR;
        end
        else if (cfg_wr_en)
        begin
            text_color_reg <= cfg_wr_data;
        end
    end

    // Cursor, scroll offset, address walker
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_row_reg <= '0;
            cursor_col_reg <= '0;
            top_reg        <= '0;
            addr_reg       <= '0;
            cnt_reg        <= '0;
            scrolled_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.clear_step)
            begin
                addr_reg <= addr_reg + ADDR_W'(1);
            end
            if (cmd.load_in)
            begin
                scrolled_reg <= 1'b0;
            end
            if (cmd.calc_addr)
            begin
                addr_reg <= addr_calc;
            end
            if (cmd.access && (func_reg == FUNC_PUT))
            begin
                cursor_row_reg <= row_next;
                cursor_col_reg <= col_next;
                if (scroll_need)
                begin
                    // old top row becomes the new bottom row
                    addr_reg     <= ADDR_W'(top_reg) * COLUMNS_A;
                    cnt_reg      <= '0;
                    scrolled_reg <= 1'b1;
                end
            end
            if (cmd.scroll_step)
            begin
                addr_reg <= addr_reg + ADDR_W'(1);
                cnt_reg  <= cnt_reg + COL_W'(1);
                if (sts.scroll_last)
                begin
                    top_reg <= (32'(top_reg) == ROWS - 1) ? '0 : top_reg + ROW_W'(1);
                end
            end
        end
    end

    // Item fields
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            func_reg <= func;
            char_reg <= char_code;
            rrow_reg <= read_row;
            rcol_reg <= read_col;
        end
        if (cmd.calc_addr)
        begin
            in_range_reg <= in_range;
        end
    end

    // Result beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            cell_out_reg     <= ((func_reg == FUNC_READ) && in_range_reg) ? rd_q_reg : '0;
            row_out_reg      <= cursor_row_reg;
            col_out_reg      <= cursor_col_reg;
            scrolled_out_reg <= scrolled_reg;
        end
    end

    // Status
    assign sts.clear_last  = (32'(addr_reg) == CELLS - 1);
    assign sts.scroll_need = scroll_need;
    assign sts.scroll_last = (32'(cnt_reg) == COLUMNS - 1);
    assign sts.out_free    = !out_valid_reg || out_ready;

    assign out_valid      = out_valid_reg;
    assign cell_value     = cell_out_reg;
    assign cursor_row_out = row_out_reg;
    assign cursor_col_out = col_out_reg;
    assign scrolled       = scrolled_out_reg;

    // Checks
    `TCW_ASSERT_ALWAYS(a_cursor_range, (32'(cursor_row_reg) < ROWS) && (32'(cursor_col_reg) < COLUMNS), "cursor off screen")
    `TCW_ASSERT_ALWAYS(a_top_range, 32'(top_reg) < ROWS, "scroll offset out of range")
    `TCW_ASSERT_NEXT(a_read_keeps_cursor, cmd.access && (func_reg == FUNC_READ), $stable(cursor_row_reg) && $stable(cursor_col_reg), "read moved cursor")

endmodule

`default_nettype wire

// ===== design/text_console_writer_top.sv =====
// Sequence: latch the input beat, form its store address, access the store, then load the result
// beat once the output is free; no new item is taken before that. A put that scrolls first has the
// single store port walk the blanked row one cell a cycle, then advances the scroll offset.
// Reset: cursor, scroll offset and attribute (0x30) reset at once; then a clearing pass
// writes all CELLS (2000) cells to 0x3020, one a cycle, with in_ready low.
`default_nettype none

module text_console_writer_top
    import tcw_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire logic [CHAR_W-1:0] cfg_wr_data,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              func,
    input  wire logic [CHAR_W-1:0] char_code,
    input  wire logic [ROW_W-1:0]  read_row,
    input  wire logic [COL_W-1:0]  read_col,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [CELL_W-1:0]      cell_value,
    output logic [ROW_W-1:0]       cursor_row_out,
    output logic [COL_W-1:0]       cursor_col_out,
    output logic                   scrolled
);

    tcw_cmd_t cmd;
    tcw_sts_t sts;

    // Sequencer
    tcw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Cursor, cell store and result register
    tcw_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .func           (func),
        .char_code      (char_code),
        .read_row       (read_row),
        .read_col       (read_col),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .cell_value     (cell_value),
        .cursor_row_out (cursor_row_out),
        .cursor_col_out (cursor_col_out),
        .scrolled       (scrolled)
    );

endmodule

`default_nettype wire
